// ===== rtl/core/blowfish_ecb_cipher_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef BLOWFISH_ECB_CIPHER_MACROS_SVH
`define BLOWFISH_ECB_CIPHER_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define BF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define BF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/bf_pkg.sv =====
package bf_pkg;

    localparam int KeyBytesMaxDef = 56;
    localparam int NumSubkeys     = 18;
    localparam int NumSwords      = 1024;
    localparam int TableWords     = NumSubkeys + NumSwords;

    typedef enum logic [1:0] {
        REQ_LOAD_TABLE = 2'd0,
        REQ_LOAD_KEY   = 2'd1,
        REQ_SCHEDULE   = 2'd2,
        REQ_BLOCK      = 2'd3
    } req_t;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_SCHED = 2'd1;
    localparam logic [1:0] KIND_BLOCK = 2'd2;

    localparam logic ADDR_MODE   = 1'b0;
    localparam logic ADDR_KEYLEN = 1'b1;

endpackage

// ===== rtl/core/blowfish_ecb_cipher.sv =====
// Blowfish 64-bit block cipher, ECB, big-endian blocks. One word is in flight at a
// time: s_tready is high only while the core is idle and drops until the result
// word has been taken. A table or key load result is raised from the load state
// after the input word is accepted. A block result passes a start state, 16
// rounds, each of an address state for the four S-box RAMs and a state that
// combines the registered read data, and a finish state. The input is ready again
// the cycle after the result word is taken. A key schedule first folds the key
// bytes into the P-array, then runs 521 chained block encryptions and reports
// kind 1. The P-array lives in flip-flops, the S-boxes in four 256-word RAMs and
// the key bytes in a RAM. Configuration (mode, key_length) is written through
// the APB port while idle; the user is bound to this, the core does not enforce it.
module blowfish_ecb_cipher #(
    parameter int KeyBytesMax = bf_pkg::KeyBytesMaxDef
) (
    input  logic        clk,
    input  logic        rst_n,
    // APB
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,  // index[10:0], data_hi[42:11], data_lo[74:43], zero
    input  logic [1:0]  s_tuser,  // req_type
    input  logic        s_tlast,  // last_block
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,  // out_hi[31:0], out_lo[63:32]
    output logic [1:0]  m_tuser,  // kind
    output logic        m_tlast   // last
);
    import bf_pkg::*;
    `include "blowfish_ecb_cipher_macros.svh"

    localparam int KaW = $clog2(KeyBytesMax);

    typedef enum logic [2:0] {
        ST_IDLE, ST_LOAD, ST_START, ST_RND_A, ST_RND_B, ST_FIN, ST_KEYX, ST_OUT
    } state_t;

    // configuration
    logic       mode_reg;
    logic [5:0] keylen_reg;
    logic       cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            keylen_reg <= 6'd8;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == ADDR_MODE)
            begin
                mode_reg <= pwdata[0];
            end
            else
            begin
                keylen_reg <= pwdata[5:0];
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == ADDR_MODE)
        begin
            prdata[0] = mode_reg;
        end
        else
        begin
            prdata[5:0] = keylen_reg;
        end
    end

    // input fields
    logic [10:0] in_index;
    logic [31:0] in_hi, in_lo;
    assign in_index = s_tdata[10:0];
    assign in_hi    = s_tdata[42:11];
    assign in_lo    = s_tdata[74:43];

    // state
    state_t      state_reg;
    logic [31:0] p_reg [NumSubkeys];
    logic [31:0] l_reg, r_reg;
    logic [3:0]  rnd_reg;
    logic        fwd_reg;
    logic        sched_reg;     // running key schedule
    logic [10:0] sptr_reg;      // table word counter during schedule
    logic [4:0]  kx_reg;        // subkey index for the key xor 0..17
    logic [6:0]  kx_cnt_reg;    // key xor byte counter
    logic [KaW-1:0] kpos_reg;
    logic [31:0] kw_reg;
    logic        last_reg;
    logic [1:0]  kind_reg;
    logic [31:0] ohi_reg, olo_reg;

    // effective key length
    logic [KaW:0] klen;
    always_comb
    begin
        if (keylen_reg == 6'd0)
        begin
            klen = (KaW+1)'(1);
        end
        else if (32'(keylen_reg) > KeyBytesMax)
        begin
            klen = (KaW+1)'(KeyBytesMax);
        end
        else
        begin
            klen = (KaW+1)'(keylen_reg);
        end
    end

    // S-box RAMs
    logic [3:0]  sb_we;
    logic [7:0]  sb_addr [4];
    logic [31:0] sb_wdata;
    logic [31:0] sb_rdata [4];

    for (genvar g = 0; g < 4; g++)
    begin : g_sbox
        bf_ram #(.Width(32), .Depth(256)) u_sbox (
            .clk  (clk),
            .we   (sb_we[g]),
            .addr (sb_addr[g]),
            .wdata(sb_wdata),
            .rdata(sb_rdata[g])
        );
    end

    // key byte RAM
    logic           kb_we;
    logic [KaW-1:0] kb_addr;
    logic [7:0]     kb_rdata;
    bf_ram #(.Width(8), .Depth(1 << KaW)) u_key (
        .clk  (clk),
        .we   (kb_we),
        .addr (kb_addr),
        .wdata(in_lo[7:0]),
        .rdata(kb_rdata)
    );

    logic accept;
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // subkey selection for the current round
    logic [4:0] pk_idx;
    assign pk_idx = fwd_reg ? {1'b0, rnd_reg} : 5'(17 - {1'b0, rnd_reg});

    logic [31:0] l_x, fval;
    assign l_x  = l_reg ^ p_reg[pk_idx];
    assign fval = ((sb_rdata[0] + sb_rdata[1]) ^ sb_rdata[2]) + sb_rdata[3];

    // final output words
    logic [31:0] fin_hi, fin_lo;
    assign fin_hi = r_reg ^ (fwd_reg ? p_reg[17] : p_reg[0]);
    assign fin_lo = l_reg ^ (fwd_reg ? p_reg[16] : p_reg[1]);

    logic [10:0] sw_idx;    // S word index written in finish of schedule
    assign sw_idx = sptr_reg - 11'(NumSubkeys);

    logic [10:0] sw_in_idx;   // S word index of a table load
    assign sw_in_idx = in_index - 11'(NumSubkeys);

    logic [10:0] sw_odd_idx;  // odd S word written after finish of schedule
    assign sw_odd_idx = sptr_reg - 11'(NumSubkeys + 1);

    // RAM addressing
    always_comb
    begin
        sb_we    = '0;
        sb_wdata = in_lo;
        for (int k = 0; k < 4; k++)
        begin
            sb_addr[k] = l_x[31-8*k -: 8];
        end
        kb_we   = 1'b0;
        kb_addr = kpos_reg;
        if (state_reg == ST_IDLE)
        begin
            kb_addr = in_index[KaW-1:0];
            if (accept && req_t'(s_tuser) == REQ_LOAD_TABLE && in_index >= 11'(NumSubkeys)
                && in_index < 11'(TableWords))
            begin
                sb_we[sw_in_idx[9:8]] = 1'b1;
                for (int k = 0; k < 4; k++)
                begin
                    sb_addr[k] = sw_in_idx[7:0];
                end
            end
            if (accept && req_t'(s_tuser) == REQ_LOAD_KEY && 32'(in_index) < KeyBytesMax)
            begin
                kb_we = 1'b1;
            end
        end
        else if (state_reg == ST_FIN && sched_reg && sptr_reg >= 11'(NumSubkeys))
        begin
            // write two S words: hi to even index, lo handled in ST_OUT
            sb_we[sw_idx[9:8]] = 1'b1;
            sb_wdata           = fin_hi;
            for (int k = 0; k < 4; k++)
            begin
                sb_addr[k] = sw_idx[7:0];
            end
        end
        else if (state_reg == ST_OUT && sched_reg && sptr_reg >= 11'(NumSubkeys + 1))
        begin
            sb_we[sw_odd_idx[9:8]] = 1'b1;
            sb_wdata               = r_reg;
            for (int k = 0; k < 4; k++)
            begin
                sb_addr[k] = sw_odd_idx[7:0];
            end
        end
    end

    // main sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sched_reg <= 1'b0;
            m_tvalid  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        last_reg <= 1'b0;
                        ohi_reg  <= '0;
                        olo_reg  <= '0;
                        kind_reg <= KIND_LOAD;
                        unique case (req_t'(s_tuser))
                            REQ_LOAD_TABLE:
                            begin
                                if (in_index < 11'(NumSubkeys))
                                begin
                                    p_reg[in_index[4:0]] <= in_lo;
                                end
                                state_reg <= ST_LOAD;
                            end
                            REQ_LOAD_KEY:
                            begin
                                state_reg <= ST_LOAD;
                            end
                            REQ_SCHEDULE:
                            begin
                                sched_reg  <= 1'b1;
                                kind_reg   <= KIND_SCHED;
                                kpos_reg   <= '0;
                                kx_cnt_reg <= '0;
                                kw_reg     <= '0;
                                kx_reg     <= '0;
                                l_reg      <= '0;
                                r_reg      <= '0;
                                sptr_reg   <= '0;
                                fwd_reg    <= 1'b1;
                                state_reg  <= ST_KEYX;
                            end
                            REQ_BLOCK:
                            begin
                                kind_reg  <= KIND_BLOCK;
                                last_reg  <= s_tlast;
                                l_reg     <= in_hi;
                                r_reg     <= in_lo;
                                fwd_reg   <= mode_reg;
                                state_reg <= ST_START;
                            end
                        endcase
                    end
                end
                ST_LOAD:
                begin
                    m_tvalid  <= 1'b1;
                    state_reg <= ST_OUT;
                end
                ST_KEYX:
                begin
                    // key byte read data arrives the cycle after its address; count 0 is the fetch
                    if (kx_cnt_reg != 7'd0)
                    begin
                        kw_reg <= {kw_reg[23:0], kb_rdata};
                        if (kx_cnt_reg[1:0] == 2'd0)
                        begin
                            p_reg[kx_reg] <= p_reg[kx_reg] ^ {kw_reg[23:0], kb_rdata};
                            kx_reg        <= kx_reg + 5'd1;
                        end
                    end
                    if ((KaW+1)'(kpos_reg) + 1'b1 >= klen)
                    begin
                        kpos_reg <= '0;
                    end
                    else
                    begin
                        kpos_reg <= kpos_reg + 1'b1;
                    end
                    kx_cnt_reg <= kx_cnt_reg + 7'd1;
                    if (kx_cnt_reg == 7'd72)
                    begin
                        state_reg <= ST_START;
                    end
                end
                ST_START:
                begin
                    rnd_reg   <= '0;
                    state_reg <= ST_RND_A;
                end
                ST_RND_A:
                begin
                    // S-box addresses from l_x presented this cycle
                    l_reg     <= l_x;
                    state_reg <= ST_RND_B;
                end
                ST_RND_B:
                begin
                    // swap halves; note l_x now reads the already xored l_reg
                    l_reg   <= r_reg ^ fval;
                    r_reg   <= l_reg;
                    rnd_reg <= rnd_reg + 4'd1;
                    if (rnd_reg == 4'd15)
                    begin
                        state_reg <= ST_FIN;
                    end
                    else
                    begin
                        state_reg <= ST_RND_A;
                    end
                end
                ST_FIN:
                begin
                    // l_reg/r_reg still hold the halves swapped by the last round
                    if (sched_reg)
                    begin
                        l_reg <= fin_hi;
                        r_reg <= fin_lo;
                        if (sptr_reg < 11'(NumSubkeys))
                        begin
                            p_reg[sptr_reg[4:0]]        <= fin_hi;
                            p_reg[sptr_reg[4:0] + 5'd1] <= fin_lo;
                        end
                        sptr_reg  <= sptr_reg + 11'd2;
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        ohi_reg   <= fin_hi;
                        olo_reg   <= fin_lo;
                        m_tvalid  <= 1'b1;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (sched_reg)
                    begin
                        // lo S word written this cycle
                        if (sptr_reg == 11'(TableWords))
                        begin
                            sched_reg <= 1'b0;
                            m_tvalid  <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= ST_START;
                        end
                    end
                    else if (m_tvalid && m_tready)
                    begin
                        m_tvalid  <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tdata = {olo_reg, ohi_reg};
    assign m_tuser = kind_reg;
    assign m_tlast = last_reg;

    `BF_ASSERT_IMP(a_ready_idle, clk, rst_n, m_tvalid, !s_tready, "accept while result pending")
    `BF_ASSERT_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid, "result dropped")
    `BF_ASSERT_IMP(a_last_kind, clk, rst_n, m_tvalid && m_tlast, m_tuser == KIND_BLOCK,
        "last on non-block result")

endmodule

// ===== rtl/core/bf_ram.sv =====
// Generic single-port RAM with registered read.
module bf_ram #(
    parameter int Width = 32,
    parameter int Depth = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== tb/sv/blowfish_ecb_cipher_test.sv =====
`timescale 1ns / 1ps

module blowfish_ecb_cipher_test;

    import bf_pkg::*;

    localparam logic [2:0] PADDR_MODE   = 3'(ADDR_MODE) << 2;
    localparam logic [2:0] PADDR_KEYLEN = 3'(ADDR_KEYLEN) << 2;
    localparam int         DRAIN_CYCLES = 60;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] hi;
        logic [31:0] lo;
        logic        last;
    } bf_result_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    // shadow of the cipher state
    logic [31:0] subkeys[NumSubkeys];
    logic [31:0] sboxes[NumSwords];
    logic [7:0]  key_mem[KeyBytesMaxDef];
    logic        enc_mode;
    logic [5:0]  key_len;

    bf_result_t  result_q[$];
    int          errors;
    int          hold_left;
    bit          idle_en;

    blowfish_ecb_cipher dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    // round function
    function automatic logic [31:0] round_f(logic [31:0] x);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        a = sboxes[x[31:24]];
        b = sboxes[256 + x[23:16]];
        c = sboxes[512 + x[15:8]];
        d = sboxes[768 + x[7:0]];
        return ((a + b) ^ c) + d;
    endfunction

    function automatic logic [63:0] crypt_block(logic [63:0] blk, bit fwd);
        logic [31:0] l;
        logic [31:0] r;
        logic [31:0] t;
        l = blk[63:32];
        r = blk[31:0];
        for (int i = 0; i < 16; i++)
        begin
            l = l ^ subkeys[fwd ? i : 17 - i];
            r = r ^ round_f(l);
            t = l;
            l = r;
            r = t;
        end
        t = l;
        l = r;
        r = t;
        r = r ^ subkeys[fwd ? 16 : 1];
        l = l ^ subkeys[fwd ? 17 : 0];
        return {l, r};
    endfunction

    task automatic expand_key();
        int          len;
        int          pos;
        logic [31:0] w;
        logic [63:0] chain;
        len = (key_len == 0) ? 1 : ((key_len > KeyBytesMaxDef) ? KeyBytesMaxDef : key_len);
        pos = 0;
        for (int i = 0; i < NumSubkeys; i++)
        begin
            w = '0;
            for (int j = 0; j < 4; j++)
            begin
                w = {w[23:0], key_mem[pos]};
                pos = (pos + 1 >= len) ? 0 : pos + 1;
            end
            subkeys[i] = subkeys[i] ^ w;
        end
        chain = '0;
        for (int i = 0; i < NumSubkeys; i += 2)
        begin
            chain = crypt_block(chain, 1'b1);
            subkeys[i]     = chain[63:32];
            subkeys[i + 1] = chain[31:0];
        end
        for (int i = 0; i < NumSwords; i += 2)
        begin
            chain = crypt_block(chain, 1'b1);
            sboxes[i]     = chain[63:32];
            sboxes[i + 1] = chain[31:0];
        end
    endtask

    // update shadow state and queue the expected word for one accepted request
    task automatic predict_request(req_t req, logic [10:0] idx, logic [31:0] hi,
                                   logic [31:0] lo, logic lastb);
        bf_result_t  res;
        logic [63:0] blk;
        res = '0;
        case (req)
            REQ_LOAD_TABLE:
            begin
                if (idx < NumSubkeys)
                    subkeys[idx] = lo;
                else if (idx < TableWords)
                    sboxes[idx - NumSubkeys] = lo;
                res.kind = KIND_LOAD;
            end
            REQ_LOAD_KEY:
            begin
                if (idx < KeyBytesMaxDef)
                    key_mem[idx] = lo[7:0];
                res.kind = KIND_LOAD;
            end
            REQ_SCHEDULE:
            begin
                expand_key();
                res.kind = KIND_SCHED;
            end
            default:
            begin
                blk = crypt_block({hi, lo}, enc_mode);
                res.kind = KIND_BLOCK;
                res.hi   = blk[63:32];
                res.lo   = blk[31:0];
                res.last = lastb;
            end
        endcase
        result_q.push_back(res);
    endtask

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // send one word on the input stream
    task automatic send_word(req_t req, logic [10:0] idx, logic [31:0] hi,
                             logic [31:0] lo, logic lastb);
        int gap;
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {5'b0, lo, hi, idx};
        s_tlast  <= lastb;
        do
            @(posedge clk);
        while (!s_tready);
        predict_request(req, idx, hi, lo, lastb);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (result_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == PADDR_MODE)
            enc_mode = data[0];
        else
            key_len = data[5:0];
    endtask

    // full table load plus key bytes, out-of-range indexes included
    task automatic test_loads();
        for (int i = 0; i < TableWords; i++)
            send_word(REQ_LOAD_TABLE, 11'(i), $urandom, $urandom, $urandom_range(0, 1));
        send_word(REQ_LOAD_TABLE, 11'(TableWords), $urandom, $urandom, 1'b0);
        send_word(REQ_LOAD_TABLE, 11'h7FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        for (int i = 0; i < KeyBytesMaxDef; i++)
            send_word(REQ_LOAD_KEY, 11'(i), $urandom, $urandom, $urandom_range(0, 1));
        send_word(REQ_LOAD_KEY, 11'(KeyBytesMaxDef), $urandom, $urandom, 1'b0);
        send_word(REQ_LOAD_KEY, 11'h7FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    endtask

    // extreme blocks in both directions
    task automatic test_block_extremes();
        for (int m = 0; m < 2; m++)
        begin
            apb_write(PADDR_MODE, 32'(m));
            send_word(REQ_BLOCK, 11'h000, 32'h0, 32'h0, 1'b0);
            send_word(REQ_BLOCK, 11'h7FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
            send_word(REQ_BLOCK, 11'h555, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
            send_word(REQ_BLOCK, 11'h2AA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1);
        end
    endtask

    // schedules with key length zero and key length above the maximum
    task automatic test_schedule_limits();
        apb_write(PADDR_KEYLEN, 32'd0);
        send_word(REQ_SCHEDULE, 11'h7FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_word(REQ_BLOCK, '0, $urandom, $urandom, 1'b1);
        apb_write(PADDR_KEYLEN, 32'd63);
        send_word(REQ_SCHEDULE, '0, 32'h0, 32'h0, 1'b0);
        send_word(REQ_BLOCK, '0, $urandom, $urandom, 1'b0);
    endtask

    // receiver held off while further blocks are offered
    task automatic test_backpressure();
        hold_left = 400;
        for (int i = 0; i < 12; i++)
            send_word(REQ_BLOCK, 11'($urandom), $urandom, $urandom, $urandom_range(0, 1));
    endtask

    task automatic random_mix(int count);
        int sel;
        for (int i = 0; i < count; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 70)
                send_word(REQ_BLOCK, 11'($urandom), $urandom, $urandom, $urandom_range(0, 1));
            else if (sel < 85)
                send_word(REQ_LOAD_KEY, ($urandom_range(0, 3) == 0) ? 11'($urandom)
                          : 11'($urandom_range(0, 63)), $urandom, $urandom,
                          $urandom_range(0, 1));
            else
                send_word(REQ_LOAD_TABLE, 11'($urandom), $urandom, $urandom,
                          $urandom_range(0, 1));
        end
    endtask

    task automatic test_random();
        apb_write(PADDR_KEYLEN, 32'd1);
        apb_write(PADDR_MODE, 32'd1);
        send_word(REQ_SCHEDULE, 11'($urandom), $urandom, $urandom, 1'b0);
        random_mix(12);
        apb_write(PADDR_MODE, 32'd0);
        random_mix(10);
        apb_write(PADDR_KEYLEN, 32'd56);
        send_word(REQ_SCHEDULE, 11'($urandom), $urandom, $urandom, 1'b1);
        random_mix(10);
        apb_write(PADDR_MODE, 32'd1);
        random_mix(10);
        idle_en = 1'b0;
        random_mix(10);
    endtask

    // result checker and receiver stalls
    initial
    begin
        bf_result_t exp_res;
        int         stall;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                if (result_q.size() == 0)
                begin
                    report("unexpected word", m_tdata[31:0], '0);
                end
                else
                begin
                    exp_res = result_q.pop_front();
                    if (m_tuser != exp_res.kind)
                        report("kind", 32'(m_tuser), 32'(exp_res.kind));
                    if (m_tdata[31:0] != exp_res.hi)
                        report("out_hi", m_tdata[31:0], exp_res.hi);
                    if (m_tdata[63:32] != exp_res.lo)
                        report("out_lo", m_tdata[63:32], exp_res.lo);
                    if (m_tlast != exp_res.last)
                        report("last", 32'(m_tlast), 32'(exp_res.last));
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (stall > 0)
            begin
                stall--;
                m_tready <= 1'b0;
            end
            else if (idle_en && $urandom_range(0, 5) == 0)
            begin
                stall = $urandom_range(0, 5);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        #20ms;
        $display("blowfish_ecb_cipher_test: FAIL");
        $finish;
    end

    initial
    begin
        clk       = 1'b0;
        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        s_tlast   = 1'b0;
        m_tready  = 1'b0;
        errors    = 0;
        hold_left = 0;
        idle_en   = 1'b1;
        enc_mode  = 1'b0;
        key_len   = 6'd8;
        for (int i = 0; i < NumSubkeys; i++)
            subkeys[i] = '0;
        for (int i = 0; i < NumSwords; i++)
            sboxes[i] = '0;
        for (int i = 0; i < KeyBytesMaxDef; i++)
            key_mem[i] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_loads();
        test_block_extremes();
        test_backpressure();
        test_schedule_limits();
        test_random();

        wait_idle();
        if (errors == 0)
            $display("blowfish_ecb_cipher_test: PASS");
        else
            $display("blowfish_ecb_cipher_test: FAIL");
        $finish;
    end

endmodule
